>>> src/msm_pkg.sv
package msm_pkg;

  localparam int unsigned QW = 17;
  localparam int unsigned TW = 16;
  localparam logic [QW-1:0] Q_ONE = 17'h10000;

  typedef enum logic [2:0] {
    SPOOL_SHUT  = 3'd0,
    SPOOL_IDLE  = 3'd1,
    SPOOL_UP    = 3'd2,
    SPOOL_UNLIM = 3'd3,
    SPOOL_DOWN  = 3'd4
  } spool_e;

  localparam logic [1:0] DES_SHUT   = 2'd0;
  localparam logic [1:0] DES_IDLE   = 2'd1;
  localparam logic [1:0] DES_UNLIM  = 2'd2;
  localparam logic [1:0] DES_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    CFG_UP_STEP   = 2'd0,
    CFG_DOWN_STEP = 2'd1,
    CFG_SAFE_TICKS = 2'd2,
    CFG_DIS_PWM   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic          armed;
    logic          interlock;
    logic [1:0]    desired_mode;
    logic          spoolup_block;
    logic          boost_set;
    logic          thrust_balanced;
  } in_item_t;

  typedef struct packed {
    logic [2:0]    spool_state;
    logic [QW-1:0] spin_up_ratio;
    logic [QW-1:0] thrust_ceiling;
    logic [QW-1:0] boost_ratio;
    logic          limits_active;
  } out_item_t;

  typedef struct packed {
    logic [QW-1:0] up_step;
    logic [QW-1:0] down_step;
    logic [TW-1:0] safe_ticks;
    logic          disable_pwm_when_disarmed;
  } cfg_t;

  typedef struct packed {
    spool_e        mode;
    logic [TW-1:0] safety_timer;
    logic [QW-1:0] spin_ramp;
    logic [QW-1:0] ceiling_ramp;
    logic [QW-1:0] boost_ramp;
    logic          boost_flag;
  } core_state_t;

endpackage

>>> src/msm_if.sv
interface msm_in_if;
  logic       valid;
  logic       ready;
  logic       armed;
  logic       interlock;
  logic [1:0] desired_mode;
  logic       spoolup_block;
  logic       boost_set;
  logic       thrust_balanced;

  modport source (output valid, armed, interlock, desired_mode, spoolup_block, boost_set,
                  thrust_balanced, input ready);
  modport sink (input valid, armed, interlock, desired_mode, spoolup_block, boost_set,
                thrust_balanced, output ready);
endinterface

interface msm_out_if
  import msm_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [2:0]    spool_state;
  logic [QW-1:0] spin_up_ratio;
  logic [QW-1:0] thrust_ceiling;
  logic [QW-1:0] boost_ratio;
  logic          limits_active;

  modport source (output valid, spool_state, spin_up_ratio, thrust_ceiling, boost_ratio,
                  limits_active, input ready);
  modport sink (input valid, spool_state, spin_up_ratio, thrust_ceiling, boost_ratio,
                limits_active, output ready);
endinterface

>>> src/motor_spool_state_machine.sv
// Motor spool state machine. Each input transaction is one control tick and
// yields exactly one result transaction carrying the new spool state, the three
// Q16 ramps (65536 = 1.0) and the limits flag. One transaction is accepted
// every clock cycle unless the output stalls; a tick passes the input
// register, then the state and result registers, and the spool state, safety
// timer and ramps are updated combinationally from it. The output register
// takes a new result in the cycle the old one is taken. Write the configuration
// registers only while no transaction is in flight.
module motor_spool_state_machine
  import msm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [QW-1:0] cfg_wdata_i,
  msm_in_if.sink        in_i,
  msm_out_if.source     out_o
);

  cfg_t        cfg;
  core_state_t st_q, st_d;
  out_item_t   res, out_q;
  in_item_t    s1_q, in_item;
  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc, advance;

  msm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msm_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .item_i (s1_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  assign in_item.armed = in_i.armed;
  assign in_item.interlock = in_i.interlock;
  assign in_item.desired_mode = in_i.desired_mode;
  assign in_item.spoolup_block = in_i.spoolup_block;
  assign in_item.boost_set = in_i.boost_set;
  assign in_item.thrust_balanced = in_i.thrust_balanced;

  // a tick retires when the output register is free or being emptied
  assign advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc = in_i.valid && in_i.ready;

  assign s1_valid_d = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      st_q.mode <= SPOOL_SHUT;
      st_q.safety_timer <= '0;
      st_q.spin_ramp <= '0;
      st_q.ceiling_ramp <= '0;
      st_q.boost_ramp <= '0;
      st_q.boost_flag <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= in_item;
    if (advance) out_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.spool_state = out_q.spool_state;
  assign out_o.spin_up_ratio = out_q.spin_up_ratio;
  assign out_o.thrust_ceiling = out_q.thrust_ceiling;
  assign out_o.boost_ratio = out_q.boost_ratio;
  assign out_o.limits_active = out_q.limits_active;

endmodule

>>> src/msm_cfg_regs.sv
module msm_cfg_regs
  import msm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [QW-1:0] cfg_wdata_i,
  output cfg_t          cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UP_STEP:    cfg_d.up_step = cfg_wdata_i;
        CFG_DOWN_STEP:  cfg_d.down_step = cfg_wdata_i;
        CFG_SAFE_TICKS: cfg_d.safe_ticks = cfg_wdata_i[TW-1:0];
        CFG_DIS_PWM:    cfg_d.disable_pwm_when_disarmed = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_step <= 17'd328;
      cfg_q.down_step <= 17'd328;
      cfg_q.safe_ticks <= 16'd400;
      cfg_q.disable_pwm_when_disarmed <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/msm_step.sv
module msm_step
  import msm_pkg::*;
(
  input  core_state_t st_i,
  input  cfg_t        cfg_i,
  input  in_item_t    item_i,
  output core_state_t st_o,
  output out_item_t   res_o
);

  function automatic logic [QW-1:0] eff_step(input logic [QW-1:0] s);
    if (s == '0) return {{(QW-1){1'b0}}, 1'b1};
    else if (s > Q_ONE) return Q_ONE;
    else return s;
  endfunction

  function automatic logic [QW-1:0] ramp_inc(input logic [QW-1:0] v, input logic [QW-1:0] s);
    logic [QW:0] r;
    r = {1'b0, v} + {1'b0, s};
    return (r > {1'b0, Q_ONE}) ? Q_ONE : r[QW-1:0];
  endfunction

  function automatic logic [QW-1:0] ramp_dec(input logic [QW-1:0] v, input logic [QW-1:0] s);
    return (v > s) ? (v - s) : '0;
  endfunction

  logic [QW-1:0] ups, dns;
  logic [1:0]    desired;
  logic          forced;
  logic          limits;
  spool_e        mode_cur;
  core_state_t   nx;

  assign ups = eff_step(cfg_i.up_step);
  assign dns = eff_step(cfg_i.down_step);
  assign forced = !item_i.armed || !item_i.interlock;

  always_comb begin
    // unused code 3 and a disarmed or interlocked vehicle both request shut down
    desired = item_i.desired_mode;
    if (desired == DES_UNUSED || forced) desired = DES_SHUT;
    mode_cur = forced ? SPOOL_SHUT : st_i.mode;

    nx = st_i;
    limits = 1'b0;

    if (item_i.armed) begin
      if (cfg_i.disable_pwm_when_disarmed && st_i.safety_timer < cfg_i.safe_ticks)
        nx.safety_timer = st_i.safety_timer + 1'b1;
      else
        nx.safety_timer = cfg_i.safe_ticks;
    end else begin
      nx.safety_timer = '0;
    end

    nx.boost_flag = st_i.boost_flag | item_i.boost_set;
    nx.mode = mode_cur;

    unique case (mode_cur)
      SPOOL_SHUT: begin
        limits = 1'b1;
        if (desired != DES_SHUT && nx.safety_timer >= cfg_i.safe_ticks) begin
          nx.mode = SPOOL_IDLE;
        end else begin
          nx.spin_ramp = '0;
          nx.ceiling_ramp = '0;
          nx.boost_flag = 1'b0;
          nx.boost_ramp = '0;
        end
      end
      SPOOL_IDLE: begin
        limits = 1'b1;
        case (desired)
          DES_SHUT: begin
            nx.spin_ramp = ramp_dec(st_i.spin_ramp, dns);
            if (st_i.spin_ramp <= dns) nx.mode = SPOOL_SHUT;
          end
          DES_UNLIM: begin
            nx.spin_ramp = ramp_inc(st_i.spin_ramp, ups);
            if (nx.spin_ramp == Q_ONE && !item_i.spoolup_block) nx.mode = SPOOL_UP;
          end
          default: nx.spin_ramp = ramp_dec(st_i.spin_ramp, dns);
        endcase
        nx.ceiling_ramp = '0;
        nx.boost_flag = 1'b0;
        nx.boost_ramp = '0;
      end
      SPOOL_UP: begin
        if (desired != DES_UNLIM) begin
          nx.mode = SPOOL_DOWN;
        end else begin
          nx.spin_ramp = Q_ONE;
          nx.ceiling_ramp = ramp_inc(st_i.ceiling_ramp, ups);
          if (nx.ceiling_ramp == Q_ONE) nx.mode = SPOOL_UNLIM;
          nx.boost_flag = 1'b0;
          nx.boost_ramp = ramp_dec(st_i.boost_ramp, ups);
        end
      end
      SPOOL_UNLIM: begin
        if (desired != DES_UNLIM) begin
          nx.mode = SPOOL_DOWN;
        end else begin
          nx.spin_ramp = Q_ONE;
          if (nx.boost_flag && !item_i.thrust_balanced)
            nx.boost_ramp = ramp_inc(st_i.boost_ramp, ups);
          else
            nx.boost_ramp = ramp_dec(st_i.boost_ramp, ups);
        end
      end
      default: begin
        if (desired == DES_UNLIM) begin
          nx.mode = SPOOL_UP;
        end else begin
          nx.spin_ramp = Q_ONE;
          nx.ceiling_ramp = ramp_dec(st_i.ceiling_ramp, dns);
          if (st_i.ceiling_ramp <= dns) nx.mode = SPOOL_IDLE;
          nx.boost_ramp = ramp_dec(st_i.boost_ramp, dns);
        end
      end
    endcase
  end

  assign st_o = nx;
  assign res_o.spool_state = nx.mode;
  assign res_o.spin_up_ratio = nx.spin_ramp;
  assign res_o.thrust_ceiling = nx.ceiling_ramp;
  assign res_o.boost_ratio = nx.boost_ramp;
  assign res_o.limits_active = limits;

endmodule

>>> src/msm_checker.sv
module msm_checker
  import msm_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid,
  input logic          out_ready,
  input logic [2:0]    spool_state,
  input logic [QW-1:0] spin_up_ratio,
  input logic [QW-1:0] thrust_ceiling,
  input logic [QW-1:0] boost_ratio,
  input logic          limits_active
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(spool_state) &&
      $stable(spin_up_ratio) && $stable(thrust_ceiling) && $stable(boost_ratio) &&
      $stable(limits_active))
    else $error("result changed while stalled");

  // shut down always reports flat ramps with limits flagged
  a_shut_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && spool_state == SPOOL_SHUT |->
      limits_active && spin_up_ratio == '0 && thrust_ceiling == '0 && boost_ratio == '0)
    else $error("shut down with nonzero ramps");

  a_unlim_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && spool_state == SPOOL_UNLIM |->
      !limits_active && spin_up_ratio == Q_ONE && thrust_ceiling == Q_ONE)
    else $error("unlimited without full ramps");

  // spin ramp is full whenever the ceiling ramp is in motion
  a_spool_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (spool_state == SPOOL_UP || spool_state == SPOOL_DOWN) |->
      spin_up_ratio == Q_ONE && thrust_ceiling <= Q_ONE && boost_ratio <= Q_ONE)
    else $error("spooling with spin ramp not full");

endmodule

bind motor_spool_state_machine msm_checker u_msm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .spool_state    (out_o.spool_state),
  .spin_up_ratio  (out_o.spin_up_ratio),
  .thrust_ceiling (out_o.thrust_ceiling),
  .boost_ratio    (out_o.boost_ratio),
  .limits_active  (out_o.limits_active)
);
